/* sv/lsbs_pkg.sv */
// ----------------------------------------------------------------------------
// lsbs_pkg
// Shared constants, register codes and beat types for the red channel LSB
// steganography embed / extract block.
// ----------------------------------------------------------------------------
package lsbs_pkg;

   // message store geometry
   localparam int unsigned MSG_DEPTH = 4096;
   localparam int unsigned MSG_AW    = $clog2(MSG_DEPTH);
   localparam int unsigned LP_W      = MSG_AW + 1;

   // field widths
   localparam int unsigned LEN_W     = 13;
   localparam int unsigned PIX_W     = 25;
   localparam int unsigned MAXLEN_W  = PIX_W - 3;
   localparam int unsigned HDR_BITS  = 32;
   localparam int unsigned HDR_W     = 32;
   localparam int unsigned HIDX_W    = $clog2(HDR_BITS);
   localparam logic [7:0]  LSB_CLEAR = 8'hFE;

   // configuration port
   localparam int unsigned CSR_AW    = 4;
   localparam int unsigned CSR_DW    = 32;

   // register indexes
   localparam logic [1:0] REG_MODE    = 2'd0;
   localparam logic [1:0] REG_MSG_LEN = 2'd1;
   localparam logic [1:0] REG_PIX_CNT = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_TOO_LONG = 2'd2;
   localparam logic [1:0] ST_BAD_HDR  = 2'd3;

   // modes and item kinds
   localparam logic MODE_EMBED   = 1'b0;
   localparam logic MODE_EXTRACT = 1'b1;
   localparam logic OP_LOAD      = 1'b0;
   localparam logic OP_PIXEL     = 1'b1;

   typedef struct packed {
      logic             mode;
      logic [LEN_W-1:0] message_length;
      logic [PIX_W-1:0] pixel_count;
   } cfg_type;

   // one result beat on its way out; use_mem means the LSB still comes from the store
   typedef struct packed {
      logic [7:0] red_out;
      logic       use_mem;
      logic [2:0] bit_sel;
      logic       byte_valid;
      logic [7:0] byte_out;
      logic       last;
      logic [1:0] status;
   } beat_type;

endpackage

/* sv/lsbs_chan_if.sv */
// ----------------------------------------------------------------------------
// lsbs channel interfaces
// Valid / ready channels for input items and result beats.
// ----------------------------------------------------------------------------
interface lsbs_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] message_byte;
   logic [7:0] red;

   modport source (output valid, output op, output message_byte, output red, input ready);
   modport sink   (input valid, input op, input message_byte, input red, output ready);
endinterface

interface lsbs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic       byte_valid;
   logic [7:0] byte_out;
   logic       last;
   logic [1:0] status;

   modport source (output valid, output red_out, output byte_valid, output byte_out,
                   output last, output status, input ready);
   modport sink   (input valid, input red_out, input byte_valid, input byte_out,
                   input last, input status, output ready);
endinterface

/* sv/lsbs_csr.sv */
// ----------------------------------------------------------------------------
// lsbs_csr
// APB-style register file: mode, message length and pixel count.
// ----------------------------------------------------------------------------
module lsbs_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [lsbs_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [lsbs_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [lsbs_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready,
   output lsbs_pkg::cfg_type            cfg,
   output logic                         cfg_wr
);
   import lsbs_pkg::*;

   logic                mode_ff,    mode_in;
   logic [LEN_W-1:0]    msg_len_ff, msg_len_in;
   logic [PIX_W-1:0]    pix_cnt_ff, pix_cnt_in;
   logic [1:0]          reg_idx;
   logic                wr_beat;

   assign reg_idx    = csr_paddr[3:2];
   assign wr_beat    = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // register write decode
   always_comb begin
      mode_in    = mode_ff;
      msg_len_in = msg_len_ff;
      pix_cnt_in = pix_cnt_ff;
      cfg_wr     = 1'b0;
      if (wr_beat) begin
         case (reg_idx)
            REG_MODE: begin
               mode_in = csr_pwdata[0];
               cfg_wr  = 1'b1;
            end
            REG_MSG_LEN: begin
               msg_len_in = csr_pwdata[LEN_W-1:0];
               cfg_wr     = 1'b1;
            end
            REG_PIX_CNT: begin
               pix_cnt_in = csr_pwdata[PIX_W-1:0];
               cfg_wr     = 1'b1;
            end
            default: begin
               cfg_wr = 1'b0;
            end
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_MODE:    csr_prdata = CSR_DW'(mode_ff);
         REG_MSG_LEN: csr_prdata = CSR_DW'(msg_len_ff);
         REG_PIX_CNT: csr_prdata = CSR_DW'(pix_cnt_ff);
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_EMBED;
         msg_len_ff <= '0;
         pix_cnt_ff <= '0;
      end else begin
         mode_ff    <= mode_in;
         msg_len_ff <= msg_len_in;
         pix_cnt_ff <= pix_cnt_in;
      end
   end

   assign cfg.mode           = mode_ff;
   assign cfg.message_length = msg_len_ff;
   assign cfg.pixel_count    = pix_cnt_ff;

endmodule

/* sv/lsbs_msg_ram.sv */
// ----------------------------------------------------------------------------
// lsbs_msg_ram
// Message byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lsbs_msg_ram (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [lsbs_pkg::MSG_AW-1:0] wr_addr,
   input  logic [7:0]                  wr_data,
   input  logic                        rd_en,
   input  logic [lsbs_pkg::MSG_AW-1:0] rd_addr,
   output logic [7:0]                  rd_data
);
   import lsbs_pkg::*;

   logic [7:0] mem [MSG_DEPTH];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/lsbs_seq.sv */
// ----------------------------------------------------------------------------
// lsbs_seq
// Stream sequencer: load pointer, pixel index, header and byte collection,
// store addressing and the first half of each result beat.
// ----------------------------------------------------------------------------
module lsbs_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  lsbs_pkg::cfg_type           cfg,
   input  logic                        cfg_wr,
   input  logic                        accept,
   input  logic                        op,
   input  logic [7:0]                  message_byte,
   input  logic [7:0]                  red,
   output logic                        ram_we,
   output logic [lsbs_pkg::MSG_AW-1:0] ram_waddr,
   output logic [7:0]                  ram_wdata,
   output logic                        ram_re,
   output logic [lsbs_pkg::MSG_AW-1:0] ram_raddr,
   output lsbs_pkg::beat_type          beat
);
   import lsbs_pkg::*;

   logic [LP_W-1:0]     load_ptr_ff, load_ptr_in;
   logic [PIX_W-1:0]    pix_idx_ff,  pix_idx_in;
   logic [HDR_W-1:0]    hdr_ff,      hdr_in;
   logic [7:0]          acc_ff,      acc_in;
   logic                err_ff,      err_in;

   logic [MAXLEN_W-1:0] max_len;
   logic [1:0]          emb_status;
   logic [PIX_W-1:0]    emb_end;
   logic [PIX_W-1:0]    k;
   logic [MAXLEN_W-1:0] q;
   logic [2:0]          ksel;
   logic [HDR_W-1:0]    len_hdr;
   logic                hbit;
   logic [HDR_W-1:0]    hdr_new;
   logic                hdr_bad;
   logic                in_msg;
   logic [7:0]          acc_new;
   logic                in_hdr;

   // per-pixel arithmetic shared by both modes
   always_comb begin
      if (cfg.pixel_count < PIX_W'(HDR_BITS)) begin
         max_len = '0;
      end else begin
         max_len = MAXLEN_W'((cfg.pixel_count - PIX_W'(HDR_BITS)) >> 3);
      end
      if (cfg.message_length == '0) begin
         emb_status = ST_EMPTY;
      end else if ((MAXLEN_W'(cfg.message_length) > max_len) ||
                   (32'(cfg.message_length) > 32'(MSG_DEPTH))) begin
         emb_status = ST_TOO_LONG;
      end else begin
         emb_status = ST_OK;
      end
      emb_end = PIX_W'(HDR_BITS) + (PIX_W'(cfg.message_length) << 3);
      in_hdr  = pix_idx_ff < PIX_W'(HDR_BITS);
      k       = pix_idx_ff - PIX_W'(HDR_BITS);
      q       = k[PIX_W-1:3];
      ksel    = k[2:0];
      len_hdr = HDR_W'(cfg.message_length);
      hbit    = len_hdr[pix_idx_ff[HIDX_W-1:0]];
      hdr_new = hdr_ff | (HDR_W'(red[0]) << pix_idx_ff[HIDX_W-1:0]);
      hdr_bad = (hdr_new == '0) || (hdr_new > HDR_W'(max_len));
      in_msg  = HDR_W'(q) < hdr_ff;
      acc_new = acc_ff | (8'(red[0]) << ksel);
   end

   // next state and beat contents
   always_comb begin
      load_ptr_in = load_ptr_ff;
      pix_idx_in  = pix_idx_ff;
      hdr_in      = hdr_ff;
      acc_in      = acc_ff;
      err_in      = err_ff;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      beat        = '0;
      if (accept) begin
         if (op == OP_LOAD) begin
            if (load_ptr_ff < LP_W'(MSG_DEPTH)) begin
               ram_we      = 1'b1;
               load_ptr_in = load_ptr_ff + LP_W'(1);
            end
         end else begin
            if (pix_idx_ff != '1) begin
               pix_idx_in = pix_idx_ff + PIX_W'(1);
            end
            beat.red_out = red;
            if (cfg.mode == MODE_EMBED) begin
               beat.status = emb_status;
               if (emb_status != ST_OK) begin
                  err_in = 1'b1;
               end else if (in_hdr) begin
                  beat.red_out = (red & LSB_CLEAR) | 8'(hbit);
               end else if (pix_idx_ff < emb_end) begin
                  // message bit is read from the store and arrives in the next cycle
                  ram_re        = 1'b1;
                  beat.use_mem  = 1'b1;
                  beat.bit_sel  = ksel;
                  beat.red_out  = red & LSB_CLEAR;
                  beat.last     = pix_idx_ff == (emb_end - PIX_W'(1));
               end
            end else begin
               if (in_hdr) begin
                  hdr_in = hdr_new;
                  if ((pix_idx_ff == PIX_W'(HDR_BITS - 1)) && hdr_bad) begin
                     err_in = 1'b1;
                  end
               end else if (!err_ff && in_msg) begin
                  acc_in = acc_new;
                  if (ksel == 3'd7) begin
                     beat.byte_valid = 1'b1;
                     beat.byte_out   = acc_new;
                     beat.last       = HDR_W'(q) == (hdr_ff - HDR_W'(1));
                     acc_in          = '0;
                  end
               end
               if (err_in) begin
                  beat.status = ST_BAD_HDR;
               end
            end
         end
      end
      // any register write restarts the pixel stream
      if (cfg_wr) begin
         pix_idx_in = '0;
         hdr_in     = '0;
         acc_in     = '0;
         err_in     = 1'b0;
      end
   end

   assign ram_waddr = load_ptr_ff[MSG_AW-1:0];
   assign ram_wdata = message_byte;
   assign ram_raddr = k[MSG_AW+2:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ptr_ff <= '0;
         pix_idx_ff  <= '0;
         hdr_ff      <= '0;
         acc_ff      <= '0;
         err_ff      <= 1'b0;
      end else begin
         load_ptr_ff <= load_ptr_in;
         pix_idx_ff  <= pix_idx_in;
         hdr_ff      <= hdr_in;
         acc_ff      <= acc_in;
         err_ff      <= err_in;
      end
   end

`ifndef SYNTHESIS
   a_load_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      load_ptr_ff <= LP_W'(MSG_DEPTH))
      else $error("load pointer ran past the store depth");

   a_cfg_restart: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> (pix_idx_ff == '0) && (hdr_ff == '0) && (acc_ff == '0) && !err_ff)
      else $error("register write did not restart the stream");

   a_load_keeps_pixel: assert property (@(posedge clock) disable iff (reset)
      (accept && (op == OP_LOAD) && !cfg_wr) |=> pix_idx_ff == $past(pix_idx_ff))
      else $error("store load moved the pixel index");
`endif

endmodule

/* sv/lsbs_out.sv */
// ----------------------------------------------------------------------------
// lsbs_out
// Store data merge stage and output register with the result handshake.
// ----------------------------------------------------------------------------
module lsbs_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_accept,
   input  lsbs_pkg::beat_type  beat_in,
   input  logic [7:0]          rd_data,
   output logic                up_ready,
   lsbs_rsp_if.source          rsp
);
   import lsbs_pkg::*;

   logic     s1_valid_ff,  s1_valid_in;
   beat_type s1_beat_ff,   s1_beat_in;
   logic     rsp_valid_ff, rsp_valid_in;
   beat_type rsp_beat_ff,  rsp_beat_in;
   beat_type merged;
   logic     s1_adv;

   // stage advance and upstream ready
   assign s1_adv   = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign up_ready = !s1_valid_ff || s1_adv;

   // fold the store bit into the red LSB
   always_comb begin
      merged = s1_beat_ff;
      if (s1_beat_ff.use_mem) begin
         merged.red_out = s1_beat_ff.red_out | 8'(rd_data[s1_beat_ff.bit_sel]);
      end
   end

   // next values of both stages
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_beat_in   = s1_beat_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_beat_in  = rsp_beat_ff;
      if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (up_accept) begin
         s1_valid_in = 1'b1;
         s1_beat_in  = beat_in;
      end
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
         rsp_beat_in  = merged;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_beat_ff  <= s1_beat_in;
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.red_out    = rsp_beat_ff.red_out;
   assign rsp.byte_valid = rsp_beat_ff.byte_valid;
   assign rsp.byte_out   = rsp_beat_ff.byte_out;
   assign rsp.last       = rsp_beat_ff.last;
   assign rsp.status     = rsp_beat_ff.status;

`ifndef SYNTHESIS
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> s1_valid_ff)
      else $error("stalled beat dropped from merge stage");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      up_accept |=> s1_valid_ff)
      else $error("accepted item did not reach merge stage");

   a_byte_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_beat_ff.byte_valid) |-> (rsp_beat_ff.status == ST_OK))
      else $error("extracted byte issued with error status");
`endif

endmodule

/* sv/lsb_red_channel_stego_embed_extract_top.sv */
// ----------------------------------------------------------------------------
// lsb_red_channel_stego_embed_extract_top
// Hides a length-prefixed byte message in the red LSBs of a pixel stream,
// or recovers it, with the message held in an on-chip byte store.
// ----------------------------------------------------------------------------
//  port      | direction | carries
//  req_ch    | in        | op, message_byte, red (store load or one pixel)
//  rsp_ch    | out       | red_out, byte_valid, byte_out, last, status
//  csr_*     | in/out    | APB-style registers: mode, message length, pixel count
//
//  One beat is taken per cycle while results drain; each item passes the merge stage,
//  where the registered store read data is folded in, and then the output register.
//  Reset clears the control state only; the message store holds no reset value.
//  A stall on rsp_ch fills the merge stage and then drops req_ch ready.
//  A register write restarts the pixel stream; the store and its load pointer stay.
// ----------------------------------------------------------------------------
module lsb_red_channel_stego_embed_extract_top (
   input  logic                         clock,
   input  logic                         reset,
   lsbs_req_if.sink                     req_ch,
   lsbs_rsp_if.source                   rsp_ch,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [lsbs_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [lsbs_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [lsbs_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import lsbs_pkg::*;

   cfg_type             cfg;
   logic                cfg_wr;
   logic                accept;
   logic                up_ready;
   logic                ram_we;
   logic [MSG_AW-1:0]   ram_waddr;
   logic [7:0]          ram_wdata;
   logic                ram_re;
   logic [MSG_AW-1:0]   ram_raddr;
   logic [7:0]          ram_rdata;
   beat_type            beat;

   // input handshake
   assign req_ch.ready = up_ready;
   assign accept       = req_ch.valid && up_ready;

   lsbs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .cfg_wr      (cfg_wr)
   );

   lsbs_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .cfg_wr       (cfg_wr),
      .accept       (accept),
      .op           (req_ch.op),
      .message_byte (req_ch.message_byte),
      .red          (req_ch.red),
      .ram_we       (ram_we),
      .ram_waddr    (ram_waddr),
      .ram_wdata    (ram_wdata),
      .ram_re       (ram_re),
      .ram_raddr    (ram_raddr),
      .beat         (beat)
   );

   lsbs_msg_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   lsbs_out u_out (
      .clock     (clock),
      .reset     (reset),
      .up_accept (accept),
      .beat_in   (beat),
      .rd_data   (ram_rdata),
      .up_ready  (up_ready),
      .rsp       (rsp_ch)
   );

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the red channel LSB steganography block. Message
// bytes and pixels are driven on the request channel and registers are
// written over the csr port. A scoreboard class tracks the store, the pixel
// position and the header / byte state, and works out the result beat of
// every accepted item. Each result beat is compared field by field, in
// order, with those predictions.
// ----------------------------------------------------------------------------
module tb_top;
   import lsbs_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned RANDOM_ITEMS = 550;
   localparam int unsigned SETTLE_WAIT  = 4;
   localparam logic [1:0]  REG_SPARE    = 2'd3;
   localparam logic [PIX_W-1:0] PIX_TOP = {PIX_W{1'b1}};

   typedef enum int {PACE_STEADY, PACE_SRC_GAPS, PACE_SINK_STALLS, PACE_BOTH} pace_t;

   typedef struct packed {
      logic [7:0] red_out;
      logic       byte_valid;
      logic [7:0] byte_out;
      logic       last;
      logic [1:0] status;
   } stego_beat_t;

   // shadow of the block: registers, message store, stream position
   class red_lsb_ledger;
      logic                  mode;
      logic [LEN_W-1:0]      msg_len;
      logic [PIX_W-1:0]      pix_cnt;
      logic [7:0]            msg_store [MSG_DEPTH];
      logic [LP_W-1:0]       load_ptr;
      logic [PIX_W-1:0]      pix_idx;
      logic [HDR_W-1:0]      hdr_shift;
      logic [7:0]            acc;
      logic                  err;
      stego_beat_t           owed_beats [$];
      int                    faults;

      function new();
         mode      = MODE_EMBED;
         msg_len   = '0;
         pix_cnt   = '0;
         load_ptr  = '0;
         faults    = 0;
         restart();
      endfunction

      function void restart();
         pix_idx   = '0;
         hdr_shift = '0;
         acc       = '0;
         err       = 1'b0;
      endfunction

      // largest message the image can carry after the header
      function int unsigned room();
         if (pix_cnt < HDR_BITS) return 0;
         return (pix_cnt - HDR_BITS) >> 3;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            REG_MODE: begin
               mode = val[0];
            end
            REG_MSG_LEN: begin
               msg_len = val[LEN_W-1:0];
            end
            REG_PIX_CNT: begin
               pix_cnt = val[PIX_W-1:0];
            end
            default: begin
               return;
            end
         endcase
         restart();
      endfunction

      // works out the beat an accepted item causes and queues it
      function void take_item(logic op, logic [7:0] mb, logic [7:0] red);
         stego_beat_t       b;
         int unsigned       span;
         int unsigned       offs;
         logic [7:0]        stored;
         logic [31:0]       len_word;
         longint unsigned   reach;
         logic [2:0]        k;
         b = '0;
         if (op == OP_LOAD) begin
            if (load_ptr < MSG_DEPTH) begin
               msg_store[load_ptr[MSG_AW-1:0]] = mb;
               load_ptr++;
            end
         end else if (mode == MODE_EMBED) begin
            b.red_out = red;
            if (msg_len == 0) b.status = ST_EMPTY;
            else if (msg_len > room() || msg_len > MSG_DEPTH) b.status = ST_TOO_LONG;
            if (b.status != ST_OK) begin
               err = 1'b1;
            end else begin
               span     = HDR_BITS + 8 * int'(msg_len);
               len_word = 32'(msg_len);
               if (pix_idx < HDR_BITS) begin
                  b.red_out = (red & LSB_CLEAR) | 8'(len_word[pix_idx[HIDX_W-1:0]]);
               end else if (pix_idx < span) begin
                  offs      = pix_idx - HDR_BITS;
                  stored    = msg_store[offs >> 3];
                  b.red_out = (red & LSB_CLEAR) | 8'(stored[offs[2:0]]);
                  if (pix_idx == span - 1) b.last = 1'b1;
               end
            end
         end else begin
            b.red_out = red;
            if (pix_idx < HDR_BITS) begin
               hdr_shift[pix_idx[HIDX_W-1:0]] = red[0];
               if (pix_idx == HDR_BITS - 1 && (hdr_shift == 0 || hdr_shift > room()))
                  err = 1'b1;
            end else if (!err) begin
               reach = 64'(HDR_BITS) + 64'(hdr_shift) * 8;
               if (64'(pix_idx) < reach) begin
                  offs   = pix_idx - HDR_BITS;
                  k      = offs[2:0];
                  acc[k] = red[0];
                  if (k == 3'd7) begin
                     b.byte_valid = 1'b1;
                     b.byte_out   = acc;
                     acc          = '0;
                     if (64'(pix_idx) == reach - 1) b.last = 1'b1;
                  end
               end
            end
            if (err) b.status = ST_BAD_HDR;
         end
         if (op == OP_PIXEL && pix_idx < PIX_TOP) pix_idx++;
         owed_beats.push_back(b);
      endfunction

      function void cmp(string what, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
            faults++;
         end
      endfunction

      function void check_beat(stego_beat_t got);
         stego_beat_t want;
         if (owed_beats.size() == 0) begin
            $display("%0t: beat with none due, expected nothing got red_out %0h status %0h",
                     $time, got.red_out, got.status);
            faults++;
            return;
         end
         want = owed_beats.pop_front();
         cmp("red_out", want.red_out, got.red_out);
         cmp("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
         cmp("byte_out", want.byte_out, got.byte_out);
         cmp("last", 8'(want.last), 8'(got.last));
         cmp("status", 8'(want.status), 8'(got.status));
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CSR_AW-1:0]   csr_paddr;
   logic [CSR_DW-1:0]   csr_pwdata;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   lsbs_req_if req_bus();
   lsbs_rsp_if rsp_bus();

   red_lsb_ledger ledger = new();
   pace_t         pace = PACE_STEADY;
   bit            stray_loads = 1'b0;
   int unsigned   items_sent = 0;
   int unsigned   cycles = 0;

   lsb_red_channel_stego_embed_extract_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   function automatic bit src_idles();
      if (pace == PACE_SRC_GAPS) return $urandom_range(0, 99) < 81;
      if (pace == PACE_BOTH) return $urandom_range(0, 99) < 9;
      return 1'b0;
   endfunction

   function automatic bit sink_stalls();
      if (pace == PACE_SINK_STALLS) return $urandom_range(0, 99) < 81;
      if (pace == PACE_BOTH) return $urandom_range(0, 99) < 9;
      return 1'b0;
   endfunction

   // one request beat, held until the block takes it
   task automatic send_item(input logic op, input logic [7:0] mb, input logic [7:0] red);
      while (src_idles()) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.op           <= op;
      req_bus.message_byte <= mb;
      req_bus.red          <= red;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      ledger.take_item(op, mb, red);
      items_sent++;
   endtask

   task automatic send_load(input logic [7:0] mb);
      send_item(OP_LOAD, mb, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_pixel(input logic [7:0] red);
      if (stray_loads && $urandom_range(0, 19) == 0) send_load(8'($urandom_range(0, 255)));
      send_item(OP_PIXEL, 8'($urandom_range(0, 255)), red);
   endtask

   // block idle: every beat back, then a settle wait for the pipeline
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (ledger.owed_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      settle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      ledger.set_reg(idx, val);
   endtask

   // random reds, with the header laid into the first 32 red lsbs if asked
   task automatic stream_pixels(input int n, input logic [31:0] hdr, input bit lay_hdr);
      logic [7:0] red;
      for (int i = 0; i < n; i++) begin
         red = 8'($urandom_range(0, 255));
         if (lay_hdr && i < HDR_BITS) red[0] = hdr[i];
         send_pixel(red);
      end
   endtask

   task automatic hide_run(input int len, input int pcnt, input int npix);
      write_reg(REG_MODE, 32'(MODE_EMBED));
      write_reg(REG_PIX_CNT, 32'(pcnt));
      write_reg(REG_MSG_LEN, 32'(len));
      stream_pixels(npix, '0, 1'b0);
   endtask

   task automatic recover_run(input logic [31:0] hdr, input int pcnt, input int npix);
      write_reg(REG_MODE, 32'(MODE_EXTRACT));
      write_reg(REG_PIX_CNT, 32'(pcnt));
      write_reg(REG_MSG_LEN, 32'($urandom_range(0, MSG_DEPTH)));
      stream_pixels(npix, hdr, 1'b1);
   endtask

   // image size either just enough plus up to 7 spare, or anything up to 1 << 24
   function automatic int pick_count(input int needed);
      if ($urandom_range(0, 1) == 0) return needed + $urandom_range(0, 7);
      return $urandom_range(needed, 1 << 24);
   endfunction

   // result side: check every beat taken, then choose the next ready
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            ledger.check_beat('{rsp_bus.red_out, rsp_bus.byte_valid, rsp_bus.byte_out,
                                rsp_bus.last, rsp_bus.status});
         rsp_bus.ready <= !sink_stalls();
      end
   end

   // watchdog
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("lsb_red_channel_stego_embed_extract_top: mismatch");
      $finish;
   end

   // stimulus
   initial begin
      int unsigned dir_items;
      int unsigned pick;
      int          len;
      int          pcnt;
      int          need;
      int          npix;
      logic [31:0] hdr;
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.op           <= OP_LOAD;
      req_bus.message_byte <= '0;
      req_bus.red          <= '0;
      csr_psel             <= 1'b0;
      csr_penable          <= 1'b0;
      csr_pwrite           <= 1'b0;
      csr_paddr            <= '0;
      csr_pwdata           <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: store extremes, empty and oversize messages, extract start
      send_load(8'h00);
      send_load(8'hFF);
      send_load(8'h55);
      send_load(8'hAA);
      send_load(8'h01);
      send_load(8'h80);
      hide_run(0, 0, 0);
      send_pixel(8'h00);
      send_pixel(8'hFF);
      send_pixel(8'h5A);
      hide_run(MSG_DEPTH, 1 << 24, 3);
      hide_run(MSG_DEPTH, HDR_BITS - 1, 3);
      hide_run(1, HDR_BITS + 7, 2);
      recover_run(32'hFFFF_FFFF, 0, 3);
      write_reg(REG_SPARE, 32'hFFFF_FFFF);
      send_pixel(8'h00);
      dir_items = items_sent;

      // random: mostly well-formed runs, some broken ones and loose loads
      stray_loads = 1'b1;
      while (items_sent < dir_items + RANDOM_ITEMS) begin
         pace = pace_t'(((items_sent - dir_items) * 4) / RANDOM_ITEMS);
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            len  = $urandom_range(1, (ledger.load_ptr < 3) ? int'(ledger.load_ptr) : 3);
            need = HDR_BITS + 8 * len;
            npix = ($urandom_range(0, 7) == 0) ? $urandom_range(1, need - 1)
                                               : need + $urandom_range(0, 6);
            hide_run(len, pick_count(need), npix);
         end else if (pick < 80) begin
            len  = $urandom_range(1, 3);
            need = HDR_BITS + 8 * len;
            recover_run(32'(len), pick_count(need), need + $urandom_range(0, 6));
         end else if (pick < 88) begin
            if ($urandom_range(0, 2) == 0) begin
               hide_run(0, $urandom_range(0, 1 << 24), $urandom_range(1, 10));
            end else begin
               len = $urandom_range(1, MSG_DEPTH);
               hide_run(len, $urandom_range(0, HDR_BITS + 8 * len - 1), $urandom_range(1, 10));
            end
         end else if (pick < 96) begin
            pcnt = $urandom_range(0, 200);
            case ($urandom_range(0, 2))
               0: begin
                  hdr = '0;
               end
               1: begin
                  hdr = 32'((pcnt < HDR_BITS) ? 0 : (pcnt - HDR_BITS) >> 3) + 1;
               end
               default: begin
                  hdr = $urandom();
               end
            endcase
            recover_run(hdr, pcnt, $urandom_range(20, 48));
         end else begin
            if ($urandom_range(0, 1) == 0) write_reg(REG_SPARE, $urandom());
            repeat ($urandom_range(1, 6)) send_load(8'($urandom_range(0, 255)));
         end
      end

      // drain and report
      req_bus.valid <= 1'b0;
      while (ledger.owed_beats.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (ledger.faults == 0)
         $display("lsb_red_channel_stego_embed_extract_top: match");
      else
         $display("lsb_red_channel_stego_embed_extract_top: mismatch");
      $finish;
   end

endmodule

/* files.f */
sv/lsbs_pkg.sv
sv/lsbs_chan_if.sv
sv/lsbs_csr.sv
sv/lsbs_msg_ram.sv
sv/lsbs_seq.sv
sv/lsbs_out.sv
sv/lsb_red_channel_stego_embed_extract_top.sv
verif/tb_top.sv
